FILE: rtl/mspt_pkg.sv
// mspt_pkg: constants, opcodes and record types of the timer slot bank
// depends on nothing; used by multi_slot_periodic_timer_bank_core
`default_nettype none

package mspt_pkg;

  // bank sizing
  localparam int unsigned TIMER_SLOTS  = 16;
  localparam int unsigned COUNT_WIDTH  = 16;
  localparam int unsigned BANK_DEPTH   = 16;
  localparam int unsigned USABLE_SLOTS = (TIMER_SLOTS < BANK_DEPTH) ? TIMER_SLOTS : BANK_DEPTH;
  localparam int unsigned ADDR_W       = (USABLE_SLOTS > 1) ? $clog2(USABLE_SLOTS) : 1;
  localparam int unsigned CNT_W        = $clog2(USABLE_SLOTS + 1);

  // fixed field widths
  localparam int unsigned SLOT_W = 4;
  localparam int unsigned TAG_W  = 16;
  localparam int unsigned OUT_W  = 16;

  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_SETUP  = 2'd1,
    OP_REMOVE = 2'd2,
    OP_QUERY  = 2'd3
  } opcode_e;

  localparam logic KIND_FIRE  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  // one memory word per slot
  typedef struct packed {
    logic [COUNT_WIDTH-1:0] count;
    logic [COUNT_WIDTH-1:0] period;
    logic [TAG_W-1:0]       tag;
    logic                   rep;
    logic                   en;
    logic                   elapsed;
  } slot_t;

  // one result transaction, without the last flag
  typedef struct packed {
    logic              kind;
    logic [SLOT_W-1:0] slot;
    logic [TAG_W-1:0]  tag;
    logic              en;
    logic              elapsed;
    logic [OUT_W-1:0]  count;
  } result_t;

endpackage

`default_nettype wire

FILE: rtl/multi_slot_periodic_timer_bank_core.sv
// multi_slot_periodic_timer_bank_core: bank of periodic timer slots kept in one memory
// depends on mspt_pkg
//
// Usage: one input channel (valid/ready) carries commands: tick, set up a slot,
// unregister a slot, query a slot. One output channel (valid/ready) carries fire
// events (kind 0) and query replies (kind 1); last marks the final result of a command.
// Slot state (count, period, tag, repeat, enable, elapsed) sits in a synchronous
// memory with a registered read; registered and written flags are flip-flops.
// Set up and unregister give no result.
// A query reads the memory, then the reply loads the output register once it is free.
// A tick sweeps the slots one per cycle, unless a stall holds the sweep, through a
// read-modify-write pipeline: the command is accepted, each slot is read from memory,
// evaluated and written back, then the sweep finishes the last slot and leaves for
// the drain state, which hands over the held event.
// Fire events are held back one place so the final one can carry last; a stalled
// receiver stalls the sweep only when a second fire event needs the output register.
// A new command is taken once the previous one is done, even while a result waits.
// Reset: no slot registered, every entry reads as zero until first set up; no
// clearing pass is needed, the memory is usable straight after reset.
`default_nettype none

module multi_slot_periodic_timer_bank_core (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_valid_i,
  output logic                           in_ready_o,
  input  wire logic [1:0]                opcode_i,
  input  wire logic [3:0]                slot_i,
  input  wire logic [15:0]               period_value_i,
  input  wire logic                      repeat_mode_i,
  input  wire logic                      start_enabled_i,
  input  wire logic signed [15:0]        user_tag_i,
  output logic                           out_valid_o,
  input  wire logic                      out_ready_i,
  output logic                           kind_o,
  output logic [3:0]                     slot_index_o,
  output logic signed [15:0]             tag_out_o,
  output logic                           is_enabled_o,
  output logic                           has_elapsed_o,
  output logic [15:0]                    count_now_o,
  output logic                           last_o
);

  localparam int unsigned AW = mspt_pkg::ADDR_W;
  localparam int unsigned CW = mspt_pkg::CNT_W;
  localparam int unsigned NW = mspt_pkg::COUNT_WIDTH;
  localparam int unsigned US = mspt_pkg::USABLE_SLOTS;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_QRY,
    ST_TICK,
    ST_DRAIN
  } state_e;

  state_e state_q;

  // slot memory and its read register
  mspt_pkg::slot_t mem [US];
  mspt_pkg::slot_t rd_q;
  logic            rd_wr_q;

  // flip-flop flags per slot
  logic [US-1:0] reg_q;
  logic [US-1:0] wr_q;

  // sweep pipeline
  logic [CW-1:0] issue_q;
  logic          proc_v_q;
  logic [AW-1:0] proc_idx_q;

  // held fire event and output register
  logic              pend_v_q;
  mspt_pkg::result_t pend_q;
  logic              out_v_q;
  mspt_pkg::result_t out_q;
  logic              out_last_q;

  // query context
  logic [3:0] q_slot_q;
  logic       q_inr_q;

  // input decode
  logic          in_acc;
  logic          in_range;
  logic [AW-1:0] in_addr;
  mspt_pkg::opcode_e op;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign op         = mspt_pkg::opcode_e'(opcode_i);
  assign in_range   = (32'(slot_i) < US);
  assign in_addr    = slot_i[AW-1:0];

  // output register is free this cycle
  logic out_free;
  assign out_free = !out_v_q || out_ready_i;

  // slot evaluation in the processing stage
  logic              active;
  logic              below;
  logic              fire;
  logic              stall;
  logic              adv;
  logic              issue_go;
  mspt_pkg::slot_t   upd;
  mspt_pkg::result_t fire_res;
  logic [31:0]       cnt_ext;

  always_comb begin
    active = proc_v_q && reg_q[proc_idx_q] && rd_q.en;
    below  = rd_q.count < rd_q.period;
    fire   = active && !below;
    stall  = fire && pend_v_q && !out_free;
    adv    = !proc_v_q || !stall;
    issue_go = (state_q == ST_TICK) && adv && (issue_q != CW'(US));

    upd = rd_q;
    if (below) begin
      upd.count = rd_q.count + NW'(1);
    end else begin
      upd.count   = '0;
      upd.elapsed = 1'b1;
      upd.en      = rd_q.rep;
    end

    fire_res.kind    = mspt_pkg::KIND_FIRE;
    fire_res.slot    = 4'(proc_idx_q);
    fire_res.tag     = rd_q.tag;
    fire_res.en      = rd_q.rep;
    fire_res.elapsed = 1'b1;
    fire_res.count   = '0;
    cnt_ext = 32'(rd_q.count);
  end

  // output register loads a new transaction this cycle
  logic out_load;
  assign out_load = ((state_q == ST_QRY) && out_free) ||
                    ((state_q == ST_TICK) && fire && !stall && pend_v_q) ||
                    ((state_q == ST_DRAIN) && pend_v_q && out_free);

  // memory write port: set up or sweep write-back
  logic            mem_we;
  logic [AW-1:0]   mem_waddr;
  mspt_pkg::slot_t mem_wdata;
  logic            mem_re;
  logic [AW-1:0]   mem_raddr;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = in_addr;
    mem_wdata.count   = '0;
    mem_wdata.period  = NW'(period_value_i);
    mem_wdata.tag     = user_tag_i;
    mem_wdata.rep     = repeat_mode_i;
    mem_wdata.en      = start_enabled_i;
    mem_wdata.elapsed = 1'b0;
    if (in_acc && op == mspt_pkg::OP_SETUP && in_range) begin
      mem_we = 1'b1;
    end else if (active && !stall) begin
      mem_we    = 1'b1;
      mem_waddr = proc_idx_q;
      mem_wdata = upd;
    end
    mem_re    = issue_go || (in_acc && op == mspt_pkg::OP_QUERY && in_range);
    mem_raddr = issue_go ? issue_q[AW-1:0] : in_addr;
  end

  // slot memory, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_q    <= mem[mem_raddr];
      rd_wr_q <= wr_q[mem_raddr];
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      q_slot_q <= slot_i;
      q_inr_q  <= in_range;
    end
    if (issue_go) begin
      proc_idx_q <= issue_q[AW-1:0];
    end
    if (fire && !stall) begin
      pend_q <= fire_res;
    end
  end

  // control state machine and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      reg_q      <= '0;
      wr_q       <= '0;
      issue_q    <= '0;
      proc_v_q   <= 1'b0;
      pend_v_q   <= 1'b0;
      out_v_q    <= 1'b0;
      out_q      <= '0;
      out_last_q <= 1'b0;
    end else begin
      // output valid: set on a load, cleared once the transaction is taken
      if (out_load) begin
        out_v_q <= 1'b1;
      end else if (out_ready_i) begin
        out_v_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            unique case (op)
              mspt_pkg::OP_TICK: begin
                state_q <= ST_TICK;
                issue_q <= '0;
              end
              mspt_pkg::OP_SETUP: begin
                if (in_range) begin
                  reg_q[in_addr] <= 1'b1;
                  wr_q[in_addr]  <= 1'b1;
                end
              end
              mspt_pkg::OP_REMOVE: begin
                if (in_range) begin
                  reg_q[in_addr] <= 1'b0;
                end
              end
              mspt_pkg::OP_QUERY: begin
                state_q <= ST_QRY;
              end
              default: begin
                state_q <= ST_IDLE;
              end
            endcase
          end
        end
        ST_QRY: begin
          if (out_free) begin
            out_last_q    <= 1'b1;
            out_q.kind    <= mspt_pkg::KIND_QUERY;
            out_q.slot    <= q_slot_q;
            if (q_inr_q && rd_wr_q) begin
              out_q.tag     <= rd_q.tag;
              out_q.en      <= rd_q.en;
              out_q.elapsed <= rd_q.elapsed;
              out_q.count   <= cnt_ext[15:0];
            end else begin
              out_q.tag     <= '0;
              out_q.en      <= 1'b0;
              out_q.elapsed <= 1'b0;
              out_q.count   <= '0;
            end
            state_q <= ST_IDLE;
          end
        end
        ST_TICK: begin
          // held event moves out when a newer fire event replaces it
          if (fire && !stall) begin
            pend_v_q <= 1'b1;
            if (pend_v_q) begin
              out_q      <= pend_q;
              out_last_q <= 1'b0;
            end
          end
          if (adv) begin
            proc_v_q <= issue_go;
          end
          if (issue_go) begin
            issue_q <= issue_q + CW'(1);
          end
          if (issue_q == CW'(US) && !proc_v_q) begin
            state_q <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          // final fire event of the tick carries last
          if (!pend_v_q) begin
            state_q <= ST_IDLE;
          end else if (out_free) begin
            out_q      <= pend_q;
            out_last_q <= 1'b1;
            pend_v_q   <= 1'b0;
            state_q    <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // output ports
  assign out_valid_o   = out_v_q;
  assign kind_o        = out_q.kind;
  assign slot_index_o  = out_q.slot;
  assign tag_out_o     = out_q.tag;
  assign is_enabled_o  = out_q.en;
  assign has_elapsed_o = out_q.elapsed;
  assign count_now_o   = out_q.count;
  assign last_o        = out_last_q;

  // no sweep work in flight while commands are taken
  assert property (@(posedge clk_i) disable iff (!rst_ni) in_ready_o |-> !proc_v_q && !pend_v_q)
    else $error("sweep state left over in idle");

  // a query reply is always the final result of its command
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o == mspt_pkg::KIND_QUERY) |-> last_o)
    else $error("query reply without last");

  // a stalled slot must not be written back
  assert property (@(posedge clk_i) disable iff (!rst_ni) stall |-> !mem_we)
    else $error("write-back during stall");

  // a stalled processing stage keeps its slot for the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall |=> proc_v_q && $stable(proc_idx_q))
    else $error("processing stage lost its slot");

endmodule

`default_nettype wire
